/* hdl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the 3x3 line-buffer convolution unit.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int KERNEL_SIZE    = 3;
    localparam int WINDOW_TAPS    = KERNEL_SIZE * KERNEL_SIZE;
    localparam int PIXEL_W        = 8;
    localparam int WEIGHT_W       = 7;
    localparam int PROD_W         = 16;
    localparam int PSUM_W         = 18;
    localparam int SUM_W          = 19;
    localparam int FILTER_MAX     = 4;
    localparam int WIDTH_CFG_W    = 11;
    localparam int HEIGHT_CFG_W   = 12;
    localparam int ROW_W          = 12;
    localparam int LIMIT_W        = 13;
    localparam int KERNEL_CFG_W   = WEIGHT_W * WINDOW_TAPS;
    localparam int CFG_INDEX_W    = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int FILTER_CNT_DEF = 4;
    localparam int TDATA_OUT_W    = 80;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 12'd1024;

    typedef logic [FILTER_MAX-1:0][KERNEL_CFG_W-1:0] kernels_t;

    localparam kernels_t KERNEL_RESET = {
        63'd562984315256960,
        63'd72624976399712385,
        63'd562984583692416,
        63'd72062026446290945
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_KERNEL_A     = 3'd2,
        REG_KERNEL_B     = 3'd3,
        REG_KERNEL_C     = 3'd4,
        REG_KERNEL_D     = 3'd5
    } reg_index_t;

    // tap r*3+c of the window
    typedef logic [WINDOW_TAPS-1:0][PIXEL_W-1:0] window_t;

    typedef struct packed {
        logic    valid;
        window_t win;
    } win_item_t;

endpackage

/* hdl/lbc_front.sv */
// ----------------------------------------------------------------------------
// lbc_front
// Raster counters, a two-line store and the 3x3 window; emits a window item
// for every position with row and column at least 2.
// ----------------------------------------------------------------------------
module lbc_front #(
    parameter int MAX_WIDTH = lbc_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lbc_pkg::PIXEL_W-1:0]          s_pixel,
    input  logic [lbc_pkg::WIDTH_CFG_W-1:0]      frame_width,
    input  logic [lbc_pkg::HEIGHT_CFG_W-1:0]     frame_height,
    input  logic                                 q_ready,
    output lbc_pkg::win_item_t                   push
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LW = lbc_pkg::LIMIT_W;
    localparam int PW = lbc_pkg::PIXEL_W;
    localparam int KS = lbc_pkg::KERNEL_SIZE;

    logic [2*PW-1:0]              line_mem [MAX_WIDTH];

    logic [AW-1:0]                col_reg, col_next;
    logic [lbc_pkg::ROW_W-1:0]    row_reg, row_next;
    logic                         s1_v_reg;
    logic [PW-1:0]                s1_px_reg;
    logic [AW-1:0]                s1_col_reg;
    logic                         s1_rowok_reg;
    logic                         s1_emit_reg;
    logic [2*PW-1:0]              rd_reg;
    logic                         fwd_hit_reg;
    logic [2*PW-1:0]              fwd_data_reg;
    lbc_pkg::window_t             win_reg, win_next;

    logic                         accept, commit;
    logic                         row_ok, col_ok;
    logic [2*PW-1:0]              eff, wdata;
    logic [LW-1:0]                col_plus, row_plus;

    assign commit   = s1_v_reg && (!s1_emit_reg || q_ready);
    assign s_tready = !s1_v_reg || commit;
    assign accept   = s_tvalid && s_tready;

    assign row_ok = row_reg >= lbc_pkg::ROW_W'(KS - 1);
    assign col_ok = col_reg >= AW'(KS - 1);

    assign col_plus = LW'(col_reg) + LW'(1);
    assign row_plus = LW'(row_reg) + LW'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_plus >= LW'(frame_width) || col_plus >= LW'(MAX_WIDTH)) begin
            col_next = '0;
            if (row_plus >= LW'(frame_height)) begin
                row_next = '0;
            end else begin
                row_next = row_plus[lbc_pkg::ROW_W-1:0];
            end
        end else begin
            col_next = col_plus[AW-1:0];
        end
    end

    // entry layout {older, newer}
    assign eff   = fwd_hit_reg ? fwd_data_reg : rd_reg;
    assign wdata = {eff[PW-1:0], s1_px_reg};

    always_comb begin
        for (int r = 0; r < KS; r++) begin
            for (int c = 0; c < KS - 1; c++) begin
                win_next[r*KS+c] = win_reg[r*KS+c+1];
            end
        end
        win_next[KS-1]      = eff[2*PW-1:PW];
        win_next[2*KS-1]    = eff[PW-1:0];
        win_next[3*KS-1]    = s1_px_reg;
    end

    assign push.valid = commit && s1_emit_reg;
    assign push.win   = win_next;

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg       <= line_mem[col_reg];
            fwd_data_reg <= wdata;
            s1_px_reg    <= s_pixel;
            s1_col_reg   <= col_reg;
        end
        if (commit) begin
            line_mem[s1_col_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_v_reg     <= 1'b0;
            s1_rowok_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            win_reg      <= '0;
        end else begin
            if (accept) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_rowok_reg <= row_ok;
                s1_emit_reg  <= row_ok && col_ok;
                // same-edge write to the line being read
                fwd_hit_reg  <= commit && (s1_col_reg == col_reg);
            end
            if (accept) begin
                s1_v_reg <= 1'b1;
            end else if (commit) begin
                s1_v_reg <= 1'b0;
            end
            if (commit && s1_rowok_reg) begin
                win_reg <= win_next;
            end
        end
    end

endmodule

/* hdl/lbc_queue.sv */
// ----------------------------------------------------------------------------
// lbc_queue
// Short FIFO of window items between the front and the filter pipeline.
// ----------------------------------------------------------------------------
module lbc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lbc_pkg::win_item_t   push,
    output logic                 q_ready,
    output lbc_pkg::win_item_t   head,
    input  logic                 pop
);

    localparam int DEPTH = lbc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    lbc_pkg::window_t   entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_push, do_pop;

    assign q_ready    = count_reg != (PTR_W+1)'(DEPTH);
    assign head.valid = count_reg != '0;
    assign head.win   = entries[rd_ptr_reg];

    assign do_push = push.valid && q_ready;
    assign do_pop  = pop && head.valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push.win;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(DEPTH))
        else $error("queue count above depth");

    a_no_lost_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> q_ready)
        else $error("window item pushed into full queue");

    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not drain queue");

endmodule

/* hdl/lbc_back.sv */
// ----------------------------------------------------------------------------
// lbc_back
// Filter pipeline: products, partial sums of three taps, final sums held
// in the output register.
// ----------------------------------------------------------------------------
module lbc_back #(
    parameter int FILTER_COUNT = lbc_pkg::FILTER_CNT_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lbc_pkg::win_item_t                    head,
    output logic                                  pop,
    input  lbc_pkg::kernels_t                     kernels,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lbc_pkg::TDATA_OUT_W-1:0]       m_tdata
);

    localparam int NF   = lbc_pkg::FILTER_MAX;
    localparam int NT   = lbc_pkg::WINDOW_TAPS;
    localparam int KS   = lbc_pkg::KERNEL_SIZE;
    localparam int WW   = lbc_pkg::WEIGHT_W;
    localparam int PW   = lbc_pkg::PIXEL_W;
    localparam int SW   = lbc_pkg::SUM_W;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic [NF-1:0][SW-1:0] sum_out;

    assign en3 = !v3_reg || m_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pop = head.valid && en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= head.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    for (genvar f = 0; f < NF; f++) begin : g_filter
        if (f < FILTER_COUNT) begin : g_used
            logic signed [lbc_pkg::PROD_W-1:0] prod_reg [NT];
            logic signed [lbc_pkg::PROD_W-1:0] prod_next [NT];
            logic signed [lbc_pkg::PSUM_W-1:0] psum_reg [KS];
            logic signed [lbc_pkg::PSUM_W-1:0] psum_next [KS];
            logic signed [SW-1:0]              sum_reg, sum_next;

            always_comb begin
                logic signed [PW:0]   pxs;
                logic signed [WW-1:0] ws;
                for (int i = 0; i < NT; i++) begin
                    pxs          = $signed({1'b0, head.win[i]});
                    ws           = $signed(kernels[f][i*WW +: WW]);
                    prod_next[i] = pxs * ws;
                end
            end

            always_comb begin
                for (int r = 0; r < KS; r++) begin
                    psum_next[r] = lbc_pkg::PSUM_W'(prod_reg[r*KS])
                                 + lbc_pkg::PSUM_W'(prod_reg[r*KS+1])
                                 + lbc_pkg::PSUM_W'(prod_reg[r*KS+2]);
                end
                sum_next = SW'(psum_reg[0]) + SW'(psum_reg[1]) + SW'(psum_reg[2]);
            end

            always_ff @(posedge aclk) begin
                if (en1) prod_reg <= prod_next;
                if (en2) psum_reg <= psum_next;
                if (en3) sum_reg  <= sum_next;
            end

            assign sum_out[f] = sum_reg;
        end else begin : g_unused
            assign sum_out[f] = '0;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {(lbc_pkg::TDATA_OUT_W - NF*SW)'(0), sum_out};

endmodule

/* hdl/line_buffer_conv3x3_multi_filter_unit.sv */
// ----------------------------------------------------------------------------
// line_buffer_conv3x3_multi_filter_unit
// 3x3 line-buffer convolution of a raster pixel stream with four kernels.
// ----------------------------------------------------------------------------
// Pixels enter on s_* in row-major order, one per item. Once row and column
// are both at least 2, one item leaves on m_* carrying the window convolved
// with each kernel as 19-bit two's complement sums; earlier positions give
// no item. Counters wrap at the configured frame size (width capped at
// MAX_WIDTH).
// Registers are written through cfg_* (always ready); the user must write
// them only while the unit is idle, which the unit does not enforce: 0 frame
// width, 1 frame height, 2..5 kernels a..d, nine 7-bit signed weights each,
// tap r*3+c at bit 7*(r*3+c). Other indexes are ignored. Throughput: one
// pixel per cycle unless the queue or output stalls. A result passes the line
// store read stage, 4-entry queue, product, partial sum and final sum stages.
// Reset clears counters, window and pipeline and restores default registers;
// line store contents are undefined and are not cleared, so no start-up pass.
// When m_tready is low the output register holds; the queue and the front
// keep accepting pixels until the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module line_buffer_conv3x3_multi_filter_unit #(
    parameter int MAX_WIDTH    = lbc_pkg::MAX_WIDTH_DEF,
    parameter int FILTER_COUNT = lbc_pkg::FILTER_CNT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [lbc_pkg::PIXEL_W-1:0]            s_tdata,   // [7:0] pixel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [18:0] sum_filter_a, [37:19] sum_filter_b, [56:38] sum_filter_c,
    // [75:57] sum_filter_d, [79:76] zero
    output logic [lbc_pkg::TDATA_OUT_W-1:0]        m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lbc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [lbc_pkg::KERNEL_CFG_W-1:0]       cfg_data
);

    logic [lbc_pkg::WIDTH_CFG_W-1:0]  width_reg;
    logic [lbc_pkg::HEIGHT_CFG_W-1:0] height_reg;
    lbc_pkg::kernels_t                kernels_reg;

    lbc_pkg::win_item_t push, head;
    logic               q_ready, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= lbc_pkg::WIDTH_RESET;
            height_reg  <= lbc_pkg::HEIGHT_RESET;
            kernels_reg <= lbc_pkg::KERNEL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lbc_pkg::REG_FRAME_WIDTH: begin
                    width_reg <= cfg_data[lbc_pkg::WIDTH_CFG_W-1:0];
                end
                lbc_pkg::REG_FRAME_HEIGHT: begin
                    height_reg <= cfg_data[lbc_pkg::HEIGHT_CFG_W-1:0];
                end
                lbc_pkg::REG_KERNEL_A: begin
                    kernels_reg[0] <= cfg_data;
                end
                lbc_pkg::REG_KERNEL_B: begin
                    kernels_reg[1] <= cfg_data;
                end
                lbc_pkg::REG_KERNEL_C: begin
                    kernels_reg[2] <= cfg_data;
                end
                lbc_pkg::REG_KERNEL_D: begin
                    kernels_reg[3] <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    lbc_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_pixel     (s_tdata),
        .frame_width (width_reg),
        .frame_height(height_reg),
        .q_ready     (q_ready),
        .push        (push)
    );

    lbc_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .q_ready(q_ready),
        .head   (head),
        .pop    (pop)
    );

    lbc_back #(
        .FILTER_COUNT(FILTER_COUNT)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .kernels (kernels_reg),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_buffer_conv3x3_multi_filter_unit.
// ----------------------------------------------------------------------------
// Pixels are streamed in whole frames under a sequence of frame sizes and
// kernel sets: the defaults after reset, the weight and pixel extremes, tiny
// and degenerate sizes and random small frames. A class tracks line stores,
// window and counters, predicts the four window sums of each result item and
// compares them field by field. The sender pauses between bursts
// of random length. The receiver stalls on its own changing pattern and
// holds off long enough for the unit to fill up and stall its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_W        = lbc_pkg::MAX_WIDTH_DEF;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [lbc_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [lbc_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef logic [lbc_pkg::FILTER_MAX-1:0][lbc_pkg::SUM_W-1:0] conv_sums_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [lbc_pkg::PIXEL_W-1:0]      s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [lbc_pkg::TDATA_OUT_W-1:0]  m_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [lbc_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [lbc_pkg::KERNEL_CFG_W-1:0] cfg_data;

    class filter_sum_check;
        logic [lbc_pkg::WIDTH_CFG_W-1:0]  frame_width;
        logic [lbc_pkg::HEIGHT_CFG_W-1:0] frame_height;
        logic [lbc_pkg::KERNEL_CFG_W-1:0] kernels [lbc_pkg::FILTER_MAX];
        logic [lbc_pkg::PIXEL_W-1:0]      older_line [MAX_W];
        logic [lbc_pkg::PIXEL_W-1:0]      newer_line [MAX_W];
        logic [lbc_pkg::PIXEL_W-1:0]      window [lbc_pkg::WINDOW_TAPS];
        int                               column;
        int                               row;
        conv_sums_t                       expected_sums [$];
        int unsigned                      errors;
        int unsigned                      checked;
        string                            field_names [lbc_pkg::FILTER_MAX];

        function new();
            int i;
            frame_width  = lbc_pkg::WIDTH_RESET;
            frame_height = lbc_pkg::HEIGHT_RESET;
            for (i = 0; i < lbc_pkg::FILTER_MAX; i++) kernels[i] = lbc_pkg::KERNEL_RESET[i];
            for (i = 0; i < lbc_pkg::WINDOW_TAPS; i++) window[i] = '0;
            column = 0;
            row = 0;
            errors = 0;
            checked = 0;
            field_names = '{"sum_filter_a", "sum_filter_b", "sum_filter_c", "sum_filter_d"};
        endfunction

        function void set_register(logic [lbc_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [lbc_pkg::KERNEL_CFG_W-1:0] data);
            case (idx)
                lbc_pkg::REG_FRAME_WIDTH:  frame_width  = data[lbc_pkg::WIDTH_CFG_W-1:0];
                lbc_pkg::REG_FRAME_HEIGHT: frame_height = data[lbc_pkg::HEIGHT_CFG_W-1:0];
                lbc_pkg::REG_KERNEL_A:     kernels[0]   = data;
                lbc_pkg::REG_KERNEL_B:     kernels[1]   = data;
                lbc_pkg::REG_KERNEL_C:     kernels[2]   = data;
                lbc_pkg::REG_KERNEL_D:     kernels[3]   = data;
                default: ;
            endcase
        endfunction

        function int weight(int f, int tap);
            logic signed [lbc_pkg::WEIGHT_W-1:0] w;
            w = kernels[f][lbc_pkg::WEIGHT_W*tap +: lbc_pkg::WEIGHT_W];
            return int'(w);
        endfunction

        function void take_pixel(logic [lbc_pkg::PIXEL_W-1:0] px);
            int col, limit, r, f, t, acc;
            conv_sums_t sums;
            col = column % MAX_W;
            if (row >= lbc_pkg::KERNEL_SIZE - 1) begin
                for (r = 0; r < lbc_pkg::KERNEL_SIZE; r++) begin
                    window[r*3]     = window[r*3 + 1];
                    window[r*3 + 1] = window[r*3 + 2];
                end
                window[2] = older_line[col];
                window[5] = newer_line[col];
                window[8] = px;
                if (col >= lbc_pkg::KERNEL_SIZE - 1) begin
                    for (f = 0; f < lbc_pkg::FILTER_MAX; f++) begin
                        acc = 0;
                        for (t = 0; t < lbc_pkg::WINDOW_TAPS; t++)
                            acc += int'(window[t]) * weight(f, t);
                        sums[f] = acc[lbc_pkg::SUM_W-1:0];
                    end
                    expected_sums.push_back(sums);
                end
            end
            older_line[col] = newer_line[col];
            newer_line[col] = px;
            limit = (int'(frame_width) < MAX_W) ? int'(frame_width) : MAX_W;
            if (col + 1 >= limit) begin
                column = 0;
                row = (row + 1 >= int'(frame_height)) ? 0 : ((row + 1) & 12'hFFF);
            end else begin
                column = col + 1;
            end
        endfunction

        function void check_sums(logic [lbc_pkg::TDATA_OUT_W-1:0] tdata);
            conv_sums_t want;
            logic signed [lbc_pkg::SUM_W-1:0] got;
            int f;
            if (expected_sums.size() == 0) begin
                $error("result item with nothing expected, tdata %h", tdata);
                errors++;
                return;
            end
            want = expected_sums.pop_front();
            checked++;
            for (f = 0; f < lbc_pkg::FILTER_MAX; f++) begin
                got = tdata[lbc_pkg::SUM_W*f +: lbc_pkg::SUM_W];
                if (got !== want[f]) begin
                    $error("%s: expected %0d, got %0d", field_names[f], $signed(want[f]), got);
                    errors++;
                end
            end
            if (tdata[lbc_pkg::TDATA_OUT_W-1:lbc_pkg::FILTER_MAX*lbc_pkg::SUM_W] !== '0) begin
                $error("tdata padding: expected 0, got %h",
                       tdata[lbc_pkg::TDATA_OUT_W-1:lbc_pkg::FILTER_MAX*lbc_pkg::SUM_W]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction
    endclass

    filter_sum_check sums_chk = new();

    int unsigned burst_left  = 0;
    int unsigned pixels_sent = 0;
    int unsigned settings    = 0;

    line_buffer_conv3x3_multi_filter_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("line_buffer_conv3x3_multi_filter_unit verification failed");
        $finish;
    end

    function automatic logic [lbc_pkg::PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return lbc_pkg::PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [lbc_pkg::KERNEL_CFG_W-1:0] pick_kernel();
        case ($urandom_range(0, 9))
            0: return {lbc_pkg::WINDOW_TAPS{7'h40}};
            1: return {lbc_pkg::WINDOW_TAPS{7'h3F}};
            2: return '0;
            3: return '1;
            default: return lbc_pkg::KERNEL_CFG_W'({$urandom, $urandom});
        endcase
    endfunction

    // pixels that bring the counters back to row 0, column 0
    function automatic int frame_pixels(int w, int h);
        int per_row;
        per_row = (w < MAX_W) ? w : MAX_W;
        if (per_row == 0) per_row = 1;
        return per_row * ((h == 0) ? 1 : h);
    endfunction

    task automatic write_reg(input logic [lbc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lbc_pkg::KERNEL_CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sums_chk.set_register(idx, data);
    endtask

    task automatic send_pixel(input logic [lbc_pkg::PIXEL_W-1:0] px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sums_chk.take_pixel(px);
        pixels_sent++;
    endtask

    // idle the input and let the pipeline empty, including pixels with no result
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sums_chk.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int w, input int h, input int frames);
        logic [lbc_pkg::KERNEL_CFG_W-1:0] d;
        d = lbc_pkg::KERNEL_CFG_W'({$urandom, $urandom});
        if ($urandom_range(0, 1)) d[lbc_pkg::KERNEL_CFG_W-1:lbc_pkg::WIDTH_CFG_W] = '0;
        d[lbc_pkg::WIDTH_CFG_W-1:0] = lbc_pkg::WIDTH_CFG_W'(w);
        write_reg(lbc_pkg::REG_FRAME_WIDTH, d);
        d = lbc_pkg::KERNEL_CFG_W'({$urandom, $urandom});
        if ($urandom_range(0, 1)) d[lbc_pkg::KERNEL_CFG_W-1:lbc_pkg::HEIGHT_CFG_W] = '0;
        d[lbc_pkg::HEIGHT_CFG_W-1:0] = lbc_pkg::HEIGHT_CFG_W'(h);
        write_reg(lbc_pkg::REG_FRAME_HEIGHT, d);
        write_reg(lbc_pkg::REG_KERNEL_A, pick_kernel());
        write_reg(lbc_pkg::REG_KERNEL_B, pick_kernel());
        write_reg(lbc_pkg::REG_KERNEL_C, pick_kernel());
        write_reg(lbc_pkg::REG_KERNEL_D, pick_kernel());
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      lbc_pkg::KERNEL_CFG_W'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
        settings++;
        repeat (frames * frame_pixels(w, h)) send_pixel(rand_pixel());
        settle();
    endtask

    initial begin : receiver
        int unsigned seg_left, mode, hold_left, seen;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        seen      = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sums_chk.check_sums(m_tdata);
                seen++;
                if (seen == 40 || seen == 300) hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(16, 200);
                end
                seg_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 9) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int i, k, random_pixels, w, h, frames;
        logic [lbc_pkg::KERNEL_CFG_W-1:0] alt_kernel;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= lbc_pkg::REG_FRAME_WIDTH;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // default kernels on a saturated 3x3 frame
        write_reg(lbc_pkg::REG_FRAME_WIDTH, lbc_pkg::KERNEL_CFG_W'(3));
        write_reg(lbc_pkg::REG_FRAME_HEIGHT, lbc_pkg::KERNEL_CFG_W'(3));
        cfg_valid <= 1'b0;
        settings++;
        repeat (9) send_pixel('1);
        settle();

        // weight extremes: most negative, most positive, alternating, zero
        for (k = 0; k < lbc_pkg::WINDOW_TAPS; k++)
            alt_kernel[lbc_pkg::WEIGHT_W*k +: lbc_pkg::WEIGHT_W] = (k % 2) ? 7'h3F : 7'h40;
        write_reg(lbc_pkg::REG_KERNEL_A, {lbc_pkg::WINDOW_TAPS{7'h40}});
        write_reg(lbc_pkg::REG_KERNEL_B, {lbc_pkg::WINDOW_TAPS{7'h3F}});
        write_reg(lbc_pkg::REG_KERNEL_C, alt_kernel);
        write_reg(lbc_pkg::REG_KERNEL_D, '0);
        cfg_valid <= 1'b0;
        settings++;
        repeat (9) send_pixel('1);
        for (i = 0; i < 9; i++) send_pixel((i % 2) ? '1 : '0);
        settle();

        // tiny and degenerate sizes
        run_phase(0, 5, 1);
        run_phase(1, 4, 2);
        run_phase(2, 6, 2);
        run_phase(6, 0, 3);
        run_phase(5, 1, 2);
        run_phase(8, 2, 2);
        run_phase(3, 3, 4);

        random_pixels = 0;
        while (random_pixels < 950) begin
            w = $urandom_range(3, 24);
            h = $urandom_range(3, 8);
            frames = $urandom_range(1, 2);
            run_phase(w, h, frames);
            random_pixels += frames * frame_pixels(w, h);
        end

        $display("%0d pixels over %0d frame and kernel settings, %0d window results checked",
                 pixels_sent, settings, sums_chk.checked);
        if (sums_chk.errors == 0) begin
            $display("line_buffer_conv3x3_multi_filter_unit verification clean");
        end else begin
            $display("line_buffer_conv3x3_multi_filter_unit verification failed");
        end
        $finish;
    end

endmodule
